/* hdl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the SysTick interval timer
// Action and verdict codes, payload structs and the sub-tick to microsecond
// conversion table.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int SUB_TICKS_PER_MS = 250;
	localparam int NUM_CHANNELS     = 8;
	localparam int CH_W             = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int US_PER_MS        = 1000;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_CHECK = 2'd1;
	localparam logic [1:0] ACT_POLL  = 2'd2;
	localparam logic [1:0] ACT_NONE  = 2'd3;

	localparam logic [1:0] VERDICT_NOT_YET = 2'd0;
	localparam logic [1:0] VERDICT_ELAPSED = 2'd1;
	localparam logic [1:0] VERDICT_LATE    = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  channel;
		logic [31:0] interval;
		logic        in_microseconds;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic        flag_was_set;
		logic [31:0] now_ms;
		logic [31:0] now_us;
	} res_t;

	// One item leaving the input register and acting on the state.
	typedef struct packed {
		logic       fire;
		logic [1:0] action;
	} step_t;

	// Time base status: current time for checks, updated time for results.
	typedef struct packed {
		logic [31:0] now_ms;
		logic [31:0] now_us;
		logic [31:0] next_ms;
		logic [31:0] next_us;
		logic        flag_was_set;
	} tb_status_t;

	typedef logic [9:0] frac_tab_t [256];

	// Microseconds elapsed within the current millisecond for each sub-tick.
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = 10'(((i % SUB_TICKS_PER_MS) * US_PER_MS) / SUB_TICKS_PER_MS);
		end
		return tab;
	endfunction

	localparam frac_tab_t FRAC_US = build_frac_tab();

endpackage

/* hdl/sit_cmd_if.sv */
// ----------------------------------------------------------------------------
// sit_cmd_if: command channel
// Valid/ready channel that carries one timer command per transfer.
// ----------------------------------------------------------------------------
interface sit_cmd_if;
	logic          valid;
	logic          ready;
	sit_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/sit_res_if.sv */
// ----------------------------------------------------------------------------
// sit_res_if: result channel
// Valid/ready channel that carries one timer result per transfer.
// ----------------------------------------------------------------------------
interface sit_res_if;
	logic          valid;
	logic          ready;
	sit_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/sit_timebase.sv */
// ----------------------------------------------------------------------------
// sit_timebase: millisecond and microsecond time base
// Sub-tick counter, millisecond count, running microsecond time and the
// one-millisecond flag.
// ----------------------------------------------------------------------------
module sit_timebase (
	input  logic                clk,
	input  logic                arst_n,
	input  sit_pkg::step_t      step,
	output sit_pkg::tb_status_t status
);

	logic [7:0]  sub_q;
	logic [31:0] ms_q;
	logic [31:0] ms1000_q;
	logic [31:0] us_q;
	logic        flag_q;

	logic [8:0]  sub_inc;
	logic        wrap;
	logic [7:0]  sub_next;
	logic [31:0] ms1000_plus;
	logic [31:0] us_in_ms;
	logic        is_tick;
	logic        is_poll;

	assign is_tick     = step.fire && (step.action == sit_pkg::ACT_TICK);
	assign is_poll     = step.fire && (step.action == sit_pkg::ACT_POLL);
	assign sub_inc     = {1'b0, sub_q} + 9'd1;
	assign wrap        = sub_inc >= 9'(sit_pkg::SUB_TICKS_PER_MS);
	assign sub_next    = wrap ? 8'd0 : sub_inc[7:0];
	assign ms1000_plus = ms1000_q + 32'(sit_pkg::US_PER_MS);
	assign us_in_ms    = ms1000_q + 32'(sit_pkg::FRAC_US[sub_inc[7:0]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= '0;
			ms_q     <= '0;
			ms1000_q <= '0;
			us_q     <= '0;
			flag_q   <= 1'b0;
		end else if (is_tick) begin
			sub_q <= sub_next;
			if (wrap) begin
				ms_q     <= ms_q + 32'd1;
				ms1000_q <= ms1000_plus;
				us_q     <= ms1000_plus;
				flag_q   <= 1'b1;
			end else begin
				us_q <= us_in_ms;
			end
		end else if (is_poll) begin
			flag_q <= 1'b0;
		end
	end

	always_comb begin
		status.now_ms       = ms_q;
		status.now_us       = us_q;
		status.next_ms      = ms_q;
		status.next_us      = us_q;
		status.flag_was_set = is_poll && flag_q;
		if (is_tick) begin
			if (wrap) begin
				status.next_ms = ms_q + 32'd1;
				status.next_us = ms1000_plus;
			end else begin
				status.next_us = us_in_ms;
			end
		end
	end

endmodule

/* hdl/sit_check.sv */
// ----------------------------------------------------------------------------
// sit_check: interval check unit
// Holds the start time of each channel and decides whether a channel's
// interval has elapsed.
// ----------------------------------------------------------------------------
module sit_check (
	input  logic           clk,
	input  logic           arst_n,
	input  sit_pkg::step_t step,
	input  logic [2:0]     channel,
	input  logic [31:0]    interval,
	input  logic           in_microseconds,
	input  logic [31:0]    now_ms,
	input  logic [31:0]    now_us,
	output logic [1:0]     verdict
);

	logic [31:0] start_q [sit_pkg::NUM_CHANNELS];

	logic [sit_pkg::CH_W-1:0] idx;
	logic                     ch_ok;
	logic [31:0]              now;
	logic [31:0]              start;
	logic [31:0]              due;
	logic [31:0]              late_mark;
	logic                     wr_en;
	logic [31:0]              wr_data;

	assign ch_ok     = 32'(channel) < 32'(sit_pkg::NUM_CHANNELS);
	assign idx       = sit_pkg::CH_W'(channel);
	assign now       = in_microseconds ? now_us : now_ms;
	assign start     = ch_ok ? start_q[idx] : 32'd0;
	assign due       = start + interval;
	assign late_mark = start + {interval[29:0], 2'b00};

	always_comb begin
		verdict = sit_pkg::VERDICT_NOT_YET;
		wr_en   = 1'b0;
		wr_data = now;
		if (ch_ok && interval != 32'd0) begin
			if (start == 32'd0) begin
				wr_en = 1'b1;
			end else if (now > late_mark) begin
				wr_en   = 1'b1;
				verdict = sit_pkg::VERDICT_LATE;
			end else if (now >= due) begin
				wr_en   = 1'b1;
				wr_data = due;
				verdict = sit_pkg::VERDICT_ELAPSED;
			end else if (now < start) begin
				wr_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sit_pkg::NUM_CHANNELS; i++) begin
				start_q[i] <= '0;
			end
		end else if (step.fire && step.action == sit_pkg::ACT_CHECK && wr_en) begin
			start_q[idx] <= wr_data;
		end
	end

endmodule

/* hdl/systick_interval_timer.sv */
// ----------------------------------------------------------------------------
// systick_interval_timer: millisecond time base with interval checks
// Counts prescaled timer ticks, keeps millisecond and microsecond time,
// a one-millisecond flag and per-channel start times for interval checks.
// ----------------------------------------------------------------------------
// A command transfer loads the input register; the command moves into the
// result register once that is free. Throughput: one command per cycle
// while results are not stalled, set by the single pass from the input
// register through the time base and check unit into the result register.
// Reset: arst_n clears the time base, the flag, all start times and both
// valid bits at once; the block accepts commands straight out of reset.
// ----------------------------------------------------------------------------
module systick_interval_timer (
	input  logic       clk,
	input  logic       arst_n,
	sit_cmd_if.sink    cmd,
	sit_res_if.source  res
);

	// Input register stage. A command waits here while the result register
	// is full and stalled; it advances as soon as that register frees up,
	// so a new command can follow in every cycle.
	logic          valid_s1;
	sit_pkg::cmd_t cmd_s1;

	// Result register. Its valid bit is the result channel's valid.
	logic          res_valid_q;
	sit_pkg::res_t res_q;

	logic                advance;
	logic                res_free;
	logic                produces;
	sit_pkg::step_t      step;
	sit_pkg::tb_status_t tb_status;
	logic [1:0]          verdict;

	assign res_free  = !res_valid_q || res.ready;
	assign advance   = valid_s1 && res_free;
	assign cmd.ready = !valid_s1 || res_free;

	// The unused action code is consumed without a result or any state change.
	assign produces    = cmd_s1.action != sit_pkg::ACT_NONE;
	assign step.fire   = advance;
	assign step.action = cmd_s1.action;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	// The time base reads the current time for checks and hands back the
	// time after this command, which is what every result reports.
	sit_timebase u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.status (tb_status)
	);

	// Interval checks compare against the time before the command; a check
	// never moves the time itself.
	sit_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.channel         (cmd_s1.channel),
		.interval        (cmd_s1.interval),
		.in_microseconds (cmd_s1.in_microseconds),
		.now_ms          (tb_status.now_ms),
		.now_us          (tb_status.now_us),
		.verdict         (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= advance && produces;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			res_q.verdict      <= (cmd_s1.action == sit_pkg::ACT_CHECK) ?
				verdict : sit_pkg::VERDICT_NOT_YET;
			res_q.flag_was_set <= tb_status.flag_was_set;
			res_q.now_ms       <= tb_status.next_ms;
			res_q.now_us       <= tb_status.next_us;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

/* hdl/sit_checker.sv */
// ----------------------------------------------------------------------------
// sit_port_checker: port-level checks of the SysTick interval timer
// Watches the result channel and checks handshake and time consistency.
// ----------------------------------------------------------------------------
module sit_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_ready,
	input sit_pkg::res_t res_data
);

	logic        seen_q;
	logic [31:0] last_ms_q;
	logic [31:0] last_us_q;
	logic        res_xfer;

	assign res_xfer = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (res_xfer) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_xfer) begin
			last_ms_q <= res_data.now_ms;
			last_us_q <= res_data.now_us;
		end
	end

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// A result never carries both a check verdict and a poll flag, and its verdict is never the unused code.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.verdict != sit_pkg::VERDICT_NOT_YET &&
			res_data.flag_was_set) && res_data.verdict != 2'd3)
		else $error("result mixes verdict and flag or has a bad verdict");

	// Checks and polls do not move time, and every tick yields a result, so
	// such a result repeats the time of the previous one.
	a_time_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && seen_q &&
		(res_data.verdict != sit_pkg::VERDICT_NOT_YET || res_data.flag_was_set)
		|-> res_data.now_ms == last_ms_q && res_data.now_us == last_us_q)
		else $error("time changed across a check or poll");

endmodule

bind systick_interval_timer sit_port_checker u_sit_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
